// File: design/hust_pkg.sv
// hust_pkg: shared constants, request and register codes, stage types
// used by every module of the usage state tracker except hust_ram; no dependencies
`default_nettype none

package hust_pkg;

  // store geometry
  localparam int AXIS_SLOTS    = 64;
  localparam int STANDARD_AXES = 10;
  localparam int SLOT_W        = $clog2(AXIS_SLOTS);
  localparam int MASK_TOP      = 63;
  localparam int VALUE_W       = 32;
  localparam int MASK_W        = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  // usage pages and id ranges
  localparam logic [15:0] PAGE_BUTTON  = 16'h0009;
  localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
  localparam logic [15:0] BTN_FIRST    = 16'd1;
  localparam logic [15:0] BTN_LAST     = 16'd32;
  localparam logic [15:0] STD_FIRST    = 16'h0030;
  localparam logic [15:0] STD_LAST     = 16'h0039;

  // request types
  localparam logic [1:0] REQ_USAGE = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_PAGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_MASK = 2'd3;

  localparam logic [MASK_W-1:0] NOTIFY_RESET = 64'h0000_0000_0000_03FF;

  // classified usage
  typedef struct packed {
    logic              is_button;
    logic [4:0]        btn_idx;
    logic              is_axis;
    logic [SLOT_W-1:0] slot;
  } decode_t;

  // one transaction held in the working stage
  typedef struct packed {
    logic [1:0]         req;
    decode_t            dec;
    logic [VALUE_W-1:0] value;
    logic               rd_ok;
    logic [SLOT_W-1:0]  rd_addr;
  } stage_t;

  // mask bit of a slot, saturating at the top bit
  function automatic logic [MASK_W-1:0] slot_bit(input logic [SLOT_W-1:0] slot);
    logic [MASK_W-1:0] b;
    if (int'(slot) > MASK_TOP) begin
      b = {1'b1, {(MASK_W-1){1'b0}}};
    end else begin
      b = {{(MASK_W-1){1'b0}}, 1'b1} << slot;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: design/hust_ram.sv
// hust_ram: generic RAM, one write port and two registered read ports
// no package dependency
`default_nettype none

module hust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// File: design/hust_decode.sv
// hust_decode: classifies a usage code into button bit or axis slot
// depends on hust_pkg
`default_nettype none

module hust_decode (
  input  wire logic [1:0]     req_type,
  input  wire logic [31:0]    usage_code,
  input  wire logic [15:0]    extra_page,
  input  wire logic [15:0]    extra_start,
  input  wire logic [7:0]     extra_count,
  output hust_pkg::decode_t   dec
);
  import hust_pkg::*;

  logic [15:0] page;
  logic [15:0] id;
  logic        hit_btn;
  logic        hit_std;
  logic        hit_ext;
  logic [16:0] ext_end;
  logic [15:0] ext_off;
  logic [8:0]  ext_slot;
  logic [15:0] std_off;
  logic [15:0] btn_off;

  assign page = usage_code[31:16];
  assign id   = usage_code[15:0];

  // range checks for the three usage rules
  always_comb begin
    ext_end  = {1'b0, extra_start} + {9'b0, extra_count};
    ext_off  = id - extra_start;
    ext_slot = {1'b0, ext_off[7:0]} + 9'(STANDARD_AXES);
    std_off  = id - STD_FIRST;
    btn_off  = id - BTN_FIRST;
    hit_btn  = (req_type == REQ_USAGE) && (page == PAGE_BUTTON)
               && (id >= BTN_FIRST) && (id <= BTN_LAST);
    hit_std  = (req_type == REQ_USAGE) && (page == PAGE_DESKTOP)
               && (id >= STD_FIRST) && (id <= STD_LAST);
    hit_ext  = (req_type == REQ_USAGE) && (page == extra_page)
               && (id >= extra_start) && ({1'b0, id} < ext_end);
  end

  // button and standard rules win over the extra page
  always_comb begin
    dec.is_button = hit_btn;
    dec.btn_idx   = btn_off[4:0];
    dec.is_axis   = 1'b0;
    dec.slot      = SLOT_W'(std_off);
    priority if (hit_btn) begin
      dec.is_axis = 1'b0;
    end else if (hit_std) begin
      dec.is_axis = 1'b1;
    end else if (hit_ext) begin
      dec.is_axis = (int'(ext_slot) < AXIS_SLOTS);
      dec.slot    = SLOT_W'(ext_slot);
    end else begin
      dec.is_axis = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: design/hust_state.sv
// hust_state: tracker state update and result register
// depends on hust_pkg; axis values come from the RAM in the top level
`default_nettype none

module hust_state (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        b_vld,
  input  wire hust_pkg::stage_t            stg,
  input  wire logic [hust_pkg::MASK_W-1:0] notify_mask,
  input  wire logic [hust_pkg::VALUE_W-1:0] rd_slot_data,
  input  wire logic [hust_pkg::VALUE_W-1:0] rd_idx_data,
  input  wire logic                        out_stall,
  output logic                             b_adv,
  output logic                             wr_en,
  output logic [hust_pkg::SLOT_W-1:0]      wr_addr,
  output logic [hust_pkg::VALUE_W-1:0]     wr_data,
  output logic                             out_valid,
  output logic [31:0]                      button_bits,
  output logic [hust_pkg::MASK_W-1:0]      present_bits,
  output logic [hust_pkg::MASK_W-1:0]      changed_bits,
  output logic                             change_flag,
  output logic                             event_flag,
  output logic signed [31:0]               read_value
);
  import hust_pkg::*;

  logic [31:0]         button_state;
  logic [MASK_W-1:0]   present_mask;
  logic [MASK_W-1:0]   changed_mask;
  logic                pending_change;
  logic                event_latch;
  logic [AXIS_SLOTS-1:0] axis_vld;

  // last write, covers the read issued in the same cycle
  logic                lw_vld;
  logic [SLOT_W-1:0]   lw_addr;
  logic [VALUE_W-1:0]  lw_data;

  logic [31:0]         button_state_next;
  logic [MASK_W-1:0]   present_mask_next;
  logic [MASK_W-1:0]   changed_mask_next;
  logic                pending_change_next;
  logic                event_latch_next;
  logic [MASK_W-1:0]   sbit;
  logic [VALUE_W-1:0]  slot_raw;
  logic [VALUE_W-1:0]  slot_old;
  logic [VALUE_W-1:0]  idx_raw;
  logic [VALUE_W-1:0]  idx_val;
  logic                ax_change;
  logic                btn_on;
  logic                btn_was;

  assign b_adv = b_vld && (!out_valid || !out_stall);

  // current value of the addressed slot
  always_comb begin
    sbit      = slot_bit(stg.dec.slot);
    slot_raw  = (lw_vld && (lw_addr == stg.dec.slot)) ? lw_data : rd_slot_data;
    slot_old  = axis_vld[stg.dec.slot] ? slot_raw : '0;
    ax_change = stg.dec.is_axis && (slot_old != stg.value);
    btn_on    = (stg.value != '0);
    btn_was   = button_state[stg.dec.btn_idx];
  end

  // next state for the transaction in the stage
  always_comb begin
    button_state_next   = button_state;
    present_mask_next   = present_mask;
    changed_mask_next   = changed_mask;
    pending_change_next = pending_change;
    event_latch_next    = event_latch;
    unique case (stg.req)
      REQ_USAGE: begin
        if (stg.dec.is_button && (btn_on != btn_was)) begin
          button_state_next[stg.dec.btn_idx] = btn_on;
          pending_change_next = 1'b1;
        end
        if (stg.dec.is_axis) begin
          present_mask_next = present_mask | sbit;
        end
        if (ax_change) begin
          changed_mask_next = changed_mask | sbit;
          if ((changed_mask_next & notify_mask) != '0) begin
            pending_change_next = 1'b1;
          end
        end
      end
      REQ_END: begin
        if (pending_change) begin
          event_latch_next = 1'b1;
        end
      end
      REQ_CLEAR: begin
        present_mask_next   = '0;
        changed_mask_next   = '0;
        pending_change_next = 1'b0;
        event_latch_next    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // axis readout after this transaction's own write
  always_comb begin
    idx_raw = (lw_vld && (lw_addr == stg.rd_addr)) ? lw_data : rd_idx_data;
    if (!stg.rd_ok) begin
      idx_val = '0;
    end else if (ax_change && (stg.dec.slot == stg.rd_addr)) begin
      idx_val = stg.value;
    end else if (axis_vld[stg.rd_addr]) begin
      idx_val = idx_raw;
    end else begin
      idx_val = '0;
    end
  end

  assign wr_en   = b_adv && ax_change;
  assign wr_addr = stg.dec.slot;
  assign wr_data = stg.value;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      button_state   <= '0;
      present_mask   <= '0;
      changed_mask   <= '0;
      pending_change <= 1'b0;
      event_latch    <= 1'b0;
      axis_vld       <= '0;
      lw_vld         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (b_adv) begin
        button_state   <= button_state_next;
        present_mask   <= present_mask_next;
        changed_mask   <= changed_mask_next;
        pending_change <= pending_change_next;
        event_latch    <= event_latch_next;
      end
      if (wr_en) begin
        axis_vld[stg.dec.slot] <= 1'b1;
        lw_vld                 <= 1'b1;
      end
      if (b_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // forwarding payload and result register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr <= stg.dec.slot;
      lw_data <= stg.value;
    end
    if (b_adv) begin
      button_bits  <= button_state_next;
      present_bits <= present_mask_next;
      changed_bits <= changed_mask_next;
      change_flag  <= pending_change_next;
      event_flag   <= event_latch_next;
      read_value   <= idx_val;
    end
  end

`ifndef SYNTHESIS
  // a clear transaction leaves both masks and flags empty
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (b_adv && (stg.req == REQ_CLEAR)) |=>
      (changed_mask == '0) && (present_mask == '0) && !pending_change && !event_latch)
    else $error("clear did not empty masks and flags");

  // a changed slot is always a present slot
  a_changed_in_present: assert property (@(posedge clk) disable iff (rst)
    (changed_mask & ~present_mask) == '0)
    else $error("changed mask has a slot that is not present");

  // the event latch only rises from a pending change
  a_event_needs_pending: assert property (@(posedge clk) disable iff (rst)
    $rose(event_latch) |-> $past(pending_change))
    else $error("event latched without a pending change");

  // the result register is loaded only by a transaction leaving the stage
  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(b_vld))
    else $error("result shown without a transaction in the stage");
`endif

endmodule

`default_nettype wire

// File: design/hid_usage_state_tracker_top.sv
// hid_usage_state_tracker_top: input stage, configuration registers, axis RAM
// depends on hust_pkg, hust_decode, hust_ram, hust_state
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    req_type usage_code usage_value read_index
//   out      output     out_valid / out_stall  button_bits present_bits changed_bits
//                                              change_flag event_flag read_value
//   cfg      input      cfg_we                 cfg_index cfg_data
//
// one transaction per cycle while the result register is not stalled; an accepted transaction
// goes into the input register (axis RAM read alongside), then a state update into the result register
// reset clears state at once: axis slots carry valid bits, no clearing pass
// in_stall rises only while a transaction waits on a stalled full result register
`default_nettype none

module hid_usage_state_tracker_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      req_type,
  input  wire logic [31:0]                     usage_code,
  input  wire logic signed [31:0]              usage_value,
  input  wire logic [5:0]                      read_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [31:0]                          button_bits,
  output logic [hust_pkg::MASK_W-1:0]          present_bits,
  output logic [hust_pkg::MASK_W-1:0]          changed_bits,
  output logic                                 change_flag,
  output logic                                 event_flag,
  output logic signed [31:0]                   read_value,
  input  wire logic                            cfg_we,
  input  wire logic [hust_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hust_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hust_pkg::*;

  logic [15:0]        extra_page;
  logic [15:0]        extra_start;
  logic [7:0]         extra_count;
  logic [MASK_W-1:0]  notify_mask;

  decode_t            dec;
  stage_t             stg_next;
  stage_t             stg;
  logic               b_vld;
  logic               b_adv;
  logic               in_acc;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [VALUE_W-1:0] rd_slot_data;
  logic [VALUE_W-1:0] rd_idx_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      extra_page  <= '0;
      extra_start <= '0;
      extra_count <= '0;
      notify_mask <= NOTIFY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXTRA_PAGE:  extra_page  <= cfg_data[15:0];
        CFG_EXTRA_START: extra_start <= cfg_data[15:0];
        CFG_EXTRA_COUNT: extra_count <= cfg_data[7:0];
        CFG_NOTIFY_MASK: notify_mask <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hust_decode u_decode (
    .req_type    (req_type),
    .usage_code  (usage_code),
    .extra_page  (extra_page),
    .extra_start (extra_start),
    .extra_count (extra_count),
    .dec         (dec)
  );

  // input handshake
  assign in_stall = b_vld && !b_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    stg_next.req     = req_type;
    stg_next.dec     = dec;
    stg_next.value   = usage_value;
    stg_next.rd_ok   = (int'(read_index) < AXIS_SLOTS);
    stg_next.rd_addr = SLOT_W'(read_index);
  end

  // working stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (in_acc) begin
      b_vld <= 1'b1;
    end else if (b_adv) begin
      b_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg <= stg_next;
    end
  end

  // axis value store, read as the transaction enters the stage
  hust_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (AXIS_SLOTS)
  ) u_axis_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (in_acc),
    .raddr_a (dec.slot),
    .raddr_b (stg_next.rd_addr),
    .rdata_a (rd_slot_data),
    .rdata_b (rd_idx_data)
  );

  hust_state u_state (
    .clk          (clk),
    .rst          (rst),
    .b_vld        (b_vld),
    .stg          (stg),
    .notify_mask  (notify_mask),
    .rd_slot_data (rd_slot_data),
    .rd_idx_data  (rd_idx_data),
    .out_stall    (out_stall),
    .b_adv        (b_adv),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .out_valid    (out_valid),
    .button_bits  (button_bits),
    .present_bits (present_bits),
    .changed_bits (changed_bits),
    .change_flag  (change_flag),
    .event_flag   (event_flag),
    .read_value   (read_value)
  );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench for hid_usage_state_tracker_top: directed and random usage traffic,
// a scoreboard that predicts every result; depends on hust_pkg and the block's RTL

module testbench;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;

  // one predicted or observed result
  typedef struct packed {
    logic [31:0] buttons;
    logic [63:0] present;
    logic [63:0] changed;
    logic        change;
    logic        evt;
    logic [31:0] axis_read;
  } tracker_view_t;

  // predicted tracker state and the results still owed by the block
  class tracker_scoreboard;
    logic [15:0] extra_page;
    logic [15:0] extra_start;
    logic [7:0]  extra_count;
    logic [63:0] notify_mask;
    logic [31:0] buttons;
    logic [31:0] axis_val [hust_pkg::AXIS_SLOTS];
    logic [63:0] present;
    logic [63:0] changed;
    logic        pend;
    logic        evt;
    tracker_view_t views_due[$];
    int n_bad;
    int n_checked;
    int n_noted;

    function new();
      extra_page = '0;
      extra_start = '0;
      extra_count = '0;
      notify_mask = hust_pkg::NOTIFY_RESET;
      buttons = '0;
      foreach (axis_val[i]) axis_val[i] = '0;
      present = '0;
      changed = '0;
      pend = 1'b0;
      evt = 1'b0;
      n_bad = 0;
      n_checked = 0;
      n_noted = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        hust_pkg::CFG_EXTRA_PAGE:  extra_page = data[15:0];
        hust_pkg::CFG_EXTRA_START: extra_start = data[15:0];
        hust_pkg::CFG_EXTRA_COUNT: extra_count = data[7:0];
        hust_pkg::CFG_NOTIFY_MASK: notify_mask = data;
        default: ;
      endcase
    endfunction

    // mask bit of a slot, pinned to the top bit
    function logic [63:0] slot_mask(int unsigned slot);
      if (slot > hust_pkg::MASK_TOP) return 64'h1 << hust_pkg::MASK_TOP;
      return 64'h1 << slot;
    endfunction

    function void store_axis(int unsigned slot, logic [31:0] value);
      if (slot >= hust_pkg::AXIS_SLOTS) return;
      if (axis_val[slot] != value) begin
        axis_val[slot] = value;
        changed |= slot_mask(slot);
        if ((changed & notify_mask) != 0) pend = 1'b1;
      end
      present |= slot_mask(slot);
    endfunction

    // button first, then standard axes, then the extra page
    function void apply_usage(logic [31:0] code, logic [31:0] value);
      int unsigned page;
      int unsigned id;
      int unsigned lo;
      logic on;
      page = code[31:16];
      id = code[15:0];
      lo = extra_start;
      if (page == hust_pkg::PAGE_BUTTON && id >= 1 && id <= 32) begin
        on = (value != 0);
        if (on != buttons[id-1]) begin
          buttons[id-1] = on;
          pend = 1'b1;
        end
      end else if (page == hust_pkg::PAGE_DESKTOP && id >= hust_pkg::STD_FIRST &&
                   id <= hust_pkg::STD_LAST) begin
        store_axis(id - hust_pkg::STD_FIRST, value);
      end else if (page == extra_page) begin
        if (id >= lo && id < lo + extra_count)
          store_axis(id - lo + hust_pkg::STANDARD_AXES, value);
      end
    endfunction

    function void note_transaction(logic [1:0] req, logic [31:0] code, logic [31:0] value,
                                   logic [5:0] ridx);
      tracker_view_t v;
      case (req)
        hust_pkg::REQ_USAGE: apply_usage(code, value);
        hust_pkg::REQ_END:   if (pend) evt = 1'b1;
        hust_pkg::REQ_CLEAR: begin
          evt = 1'b0;
          pend = 1'b0;
          changed = '0;
          present = '0;
        end
        default: ;
      endcase
      v.buttons = buttons;
      v.present = present;
      v.changed = changed;
      v.change = pend;
      v.evt = evt;
      v.axis_read = (ridx < hust_pkg::AXIS_SLOTS) ? axis_val[ridx] : '0;
      views_due.push_back(v);
      n_noted++;
    endfunction

    function void field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        n_bad++;
      end
    endfunction

    function void check_result(tracker_view_t got);
      tracker_view_t want;
      if (views_due.size() == 0) begin
        $error("result with no transaction waiting");
        n_bad++;
        return;
      end
      want = views_due.pop_front();
      n_checked++;
      field_ok("button_bits", want.buttons, got.buttons);
      field_ok("present_bits", want.present, got.present);
      field_ok("changed_bits", want.changed, got.changed);
      field_ok("change_flag", want.change, got.change);
      field_ok("event_flag", want.evt, got.evt);
      field_ok("read_value", want.axis_read, got.axis_read);
    endfunction

    function void flush_check();
      if (views_due.size() != 0) begin
        $error("%0d results never arrived", views_due.size());
        n_bad++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [31:0] usage_code = '0;
  logic signed [31:0] usage_value = '0;
  logic [5:0]  read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] button_bits;
  logic [hust_pkg::MASK_W-1:0] present_bits;
  logic [hust_pkg::MASK_W-1:0] changed_bits;
  logic        change_flag;
  logic        event_flag;
  logic signed [31:0] read_value;
  logic        cfg_we = 1'b0;
  logic [hust_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hust_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tracker_scoreboard sb = new();

  bit calm = 1'b0;
  int useful = 0;
  int n_settings = 0;
  int hold_asks = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  hid_usage_state_tracker_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .usage_code(usage_code),
    .usage_value(usage_value), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .button_bits(button_bits), .present_bits(present_bits),
    .changed_bits(changed_bits), .change_flag(change_flag),
    .event_flag(event_flag), .read_value(read_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: check accepted results, stall at random or for a long hold
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({button_bits, present_bits, changed_bits, change_flag,
                       event_flag, read_value});
    if (hold_taken != hold_asks) begin
      hold_taken = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  // watchdog on cycles without any accepted transaction or taken result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one transaction, hold it until accepted, then maybe leave a gap
  task automatic send_item(input logic [1:0] req, input logic [31:0] code,
                           input logic [31:0] value, input logic [5:0] ridx);
    int gap;
    in_valid <= 1'b1;
    req_type <= req;
    usage_code <= code;
    usage_value <= value;
    read_index <= ridx;
    do @(posedge clk); while (in_stall);
    sb.note_transaction(req, code, value, ridx);
    if (req != REQ_UNUSED) useful++;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 14) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and let every owed result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.views_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] page, input logic [15:0] first_id,
                          input logic [7:0] count, input logic [63:0] notify);
    wait_idle();
    write_reg(hust_pkg::CFG_EXTRA_PAGE, {48'h0, page});
    write_reg(hust_pkg::CFG_EXTRA_START, {48'h0, first_id});
    write_reg(hust_pkg::CFG_EXTRA_COUNT, {56'h0, count});
    write_reg(hust_pkg::CFG_NOTIFY_MASK, notify);
    n_settings++;
  endtask

  // usage codes biased toward buttons, standard axes and the extra range
  function automatic logic [31:0] pick_code();
    int r;
    logic [15:0] id;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      id = 16'($urandom_range(1, 32));
      if ($urandom_range(0, 9) == 0) id = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd33;
      return {hust_pkg::PAGE_BUTTON, id};
    end else if (r < 65) begin
      id = 16'($urandom_range(hust_pkg::STD_FIRST, hust_pkg::STD_LAST));
      if ($urandom_range(0, 9) == 0) id = ($urandom_range(0, 1) == 0) ? 16'h2F : 16'h3A;
      return {hust_pkg::PAGE_DESKTOP, id};
    end else if (r < 85) begin
      id = sb.extra_start + 16'($urandom_range(0, int'(sb.extra_count) + 2));
      if ($urandom_range(0, 15) == 0) id = sb.extra_start - 16'd1;
      return {sb.extra_page, id};
    end
    return $urandom;
  endfunction

  // small values repeat often so unchanged writes happen
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 3);
    if (r < 55) return 32'h0;
    if (r < 62) return 32'h7FFF_FFFF;
    if (r < 69) return 32'h8000_0000;
    if (r < 74) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_read_index();
    if ($urandom_range(0, 99) < 60) return 6'($urandom_range(0, 29));
    return 6'($urandom_range(0, 63));
  endfunction

  // reports of random usages closed by an end, with clears and noise mixed in
  task automatic run_reports(input int target);
    int goal;
    int k;
    int r;
    goal = useful + target;
    while (useful < goal) begin
      k = $urandom_range(1, 8);
      repeat (k) send_item(hust_pkg::REQ_USAGE, pick_code(), pick_value(), pick_read_index());
      if ($urandom_range(0, 99) < 85)
        send_item(hust_pkg::REQ_END, $urandom, $urandom, pick_read_index());
      r = $urandom_range(0, 99);
      if (r < 8)
        send_item(hust_pkg::REQ_CLEAR, $urandom, $urandom, pick_read_index());
      else if (r < 16)
        send_item(2'($urandom_range(0, 3)), $urandom, $urandom, 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // buttons: lowest and highest, repeated press, ids just outside the range
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0001, 32'd1, 6'd0);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0020, 32'h8000_0000, 6'd0);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0020, 32'd5, 6'd0);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0000, 32'd1, 6'd0);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0021, 32'd1, 6'd0);
    // report end with and without a pending change around a clear
    send_item(hust_pkg::REQ_END, 32'h0, 32'h0, 6'd0);
    send_item(hust_pkg::REQ_CLEAR, 32'h0, 32'h0, 6'd0);
    send_item(hust_pkg::REQ_END, 32'h0, 32'h0, 6'd0);
    // standard axes at both ends, a repeated value, ids just outside
    send_item(hust_pkg::REQ_USAGE, 32'h0001_0030, 32'h7FFF_FFFF, 6'd0);
    send_item(hust_pkg::REQ_USAGE, 32'h0001_0039, 32'h8000_0000, 6'd9);
    send_item(hust_pkg::REQ_USAGE, 32'h0001_0039, 32'h8000_0000, 6'd9);
    send_item(hust_pkg::REQ_USAGE, 32'h0001_002F, 32'd7, 6'd63);
    send_item(hust_pkg::REQ_USAGE, 32'h0001_003A, 32'd7, 6'd63);
    // unused request type leaves the state alone
    send_item(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0001, 32'd0, 6'd0);
    send_item(hust_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);

    // extra page on the button page: buttons win, slots past the store dropped
    set_regs(16'h0009, 16'h0000, 8'd255, 64'h0);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0005, 32'd1, 6'd0);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0028, 32'd3, 6'd50);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_003C, 32'd3, 6'd50);
    send_item(hust_pkg::REQ_USAGE, 32'h0009_0000, 32'd9, 6'd10);
    send_item(hust_pkg::REQ_END, 32'h0, 32'h0, 6'd10);

    // extra page on the desktop page: standard axes keep their ids
    set_regs(16'h0001, 16'h0030, 8'd20, '1);
    send_item(hust_pkg::REQ_CLEAR, 32'h0, 32'h0, 6'd0);
    send_item(hust_pkg::REQ_USAGE, 32'h0001_0035, 32'd4, 6'd5);
    send_item(hust_pkg::REQ_USAGE, 32'h0001_003A, 32'd4, 6'd20);
    send_item(hust_pkg::REQ_USAGE, 32'h0001_0043, 32'd1, 6'd29);
    send_item(hust_pkg::REQ_USAGE, 32'h0001_0044, 32'd1, 6'd30);
    send_item(hust_pkg::REQ_END, 32'h0, 32'h0, 6'd29);

    // random phases over several register settings
    set_regs(16'h0000, 16'h0000, 8'd0, hust_pkg::NOTIFY_RESET);
    run_reports(300);

    // top extremes, with a long result hold while input keeps coming
    set_regs(16'hFFFF, 16'hFFFF, 8'd255, '1);
    hold_asks++;
    run_reports(300);

    // a stretch with no idling on either side
    set_regs(16'h0009, 16'h0000, 8'd255, 64'h0);
    calm = 1'b1;
    run_reports(300);
    calm = 1'b0;

    set_regs(16'h0001, 16'h0030, 8'd60, {$urandom, $urandom});
    run_reports(300);

    set_regs(16'($urandom), 16'($urandom), 8'($urandom), {$urandom, $urandom});
    run_reports(300);

    set_regs(16'h0000, 16'h0010, 8'd54, {$urandom, $urandom} | hust_pkg::NOTIFY_RESET);
    run_reports(300);

    wait_idle();
    repeat (8) @(posedge clk);
    sb.flush_check();
    $display("ran %0d transactions under %0d register settings, %0d results checked",
             sb.n_noted, n_settings, sb.n_checked);
    $display("buttons, standard and extra axes, report ends, clears and noise exercised");
    if (sb.n_bad == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
